// ===== rtl/wpbl_pkg.sv =====
// Shared types, constants and register codes of the wheel power budget limiter.
package wpbl_pkg;

  localparam int MOTORS  = 4;
  localparam int FIELD_W = 15;
  localparam int BUF_W   = 9;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_POWER_LIMIT = 3'd0;
  localparam logic [IDX_W-1:0] REG_TORQUE      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CURRENT_SQ  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPEED_SQ    = 3'd3;
  localparam logic [IDX_W-1:0] REG_STATIC      = 3'd4;
  localparam logic [IDX_W-1:0] REG_ENTER_LOW   = 3'd5;
  localparam logic [IDX_W-1:0] REG_EXIT_LOW    = 3'd6;
  localparam logic [IDX_W-1:0] REG_CLAMP       = 3'd7;

  // The budget is floor(power_limit * 75 * 2^16 / 85), formed as a multiply by the
  // rounded-up reciprocal of 85 scaled by 2^39, which is exact for a 32-bit dividend.
  localparam logic [31:0] BUDGET_SCALE = 32'd4915200;
  localparam logic [63:0] BUDGET_RECIP = 64'd6467715458;
  localparam int          BUDGET_SHIFT = 39;
  localparam logic [5:0]  PEN_HOLD_W   = 6'd25;
  localparam logic [5:0]  PEN_ENTRY_W  = 6'd35;

  typedef logic signed [FIELD_W-1:0] fld_t;

  typedef enum logic [1:0] {
    PEN_NONE,
    PEN_HOLD,
    PEN_ENTRY
  } pen_e;

  typedef struct packed {
    fld_t [MOTORS-1:0] speed;
    fld_t [MOTORS-1:0] cmd;
    pen_e              pen;
    logic              low;
  } item_t;

  typedef struct packed {
    fld_t [MOTORS-1:0] limit;
    logic              over;
    logic              low;
  } result_t;

  typedef struct packed {
    logic [8:0]  power_limit;
    logic [23:0] torque;
    logic [23:0] current_sq;
    logic [23:0] speed_sq;
    logic [21:0] static_pw;
    logic [8:0]  enter_low;
    logic [8:0]  exit_low;
    logic [13:0] clamp;
  } cfg_t;

  typedef enum logic [1:0] {
    MDU_MUL,
    MDU_DIV,
    MDU_SQRT
  } mdu_op_e;

  typedef struct packed {
    mdu_op_e     op;
    logic [87:0] x;
    logic [63:0] y;
  } mdu_req_t;

  function automatic logic [5:0] pen_watts(input pen_e pen);
    logic [5:0] w;
    w = 6'd0;
    case (pen)
      PEN_HOLD:  w = PEN_HOLD_W;
      PEN_ENTRY: w = PEN_ENTRY_W;
      default:   w = 6'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/wpbl_queue.sv =====
// Two-entry queue that carries classified ticks from the front end to the solver.
module wpbl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wpbl_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  output wpbl_pkg::item_t item_o,
  input  logic           pop_i
);
  import wpbl_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/wpbl_front.sv =====
// Front end: takes input transfers, runs the low-buffer hysteresis and queues each tick.
module wpbl_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [8:0]                         enter_low_i,
  input  logic [8:0]                         exit_low_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  wpbl_pkg::fld_t [wpbl_pkg::MOTORS-1:0] speed_i,
  input  wpbl_pkg::fld_t [wpbl_pkg::MOTORS-1:0] cmd_i,
  input  logic [wpbl_pkg::BUF_W-1:0]         buffer_energy_i,
  input  logic                               full_i,
  output logic                               push_o,
  output wpbl_pkg::item_t                    item_o
);
  import wpbl_pkg::*;

  logic low_q, low_d;
  pen_e pen;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    low_d = low_q;
    pen   = PEN_NONE;
    if (low_q) begin
      pen = PEN_HOLD;
      if (buffer_energy_i >= exit_low_i) begin
        low_d = 1'b0;
      end
    end else if (buffer_energy_i < enter_low_i) begin
      pen   = PEN_ENTRY;
      low_d = 1'b1;
    end
  end

  always_comb begin
    item_o.speed = speed_i;
    item_o.cmd   = cmd_i;
    item_o.pen   = pen;
    item_o.low   = low_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= 1'b0;
    end else if (push_o) begin
      low_q <= low_d;
    end
  end

endmodule

// ===== rtl/wpbl_mdu.sv =====
// Shared arithmetic unit: four-pass 64x64 multiply, radix-2 divide and bitwise square root.
module wpbl_mdu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  wpbl_pkg::mdu_req_t req_i,
  output logic               done_o,
  output logic [127:0]       res_o
);
  import wpbl_pkg::*;

  localparam logic [6:0] MUL_LAST  = 7'd4;
  localparam logic [6:0] DIV_LAST  = 7'd63;
  localparam logic [6:0] SQRT_LAST = 7'd43;

  logic         busy_q;
  logic         done_q;
  logic         pv_q;
  mdu_op_e      op_q;
  logic [6:0]   cnt_q;
  logic [6:0]   last;
  logic [87:0]  x_q;
  logic [63:0]  y_q;
  logic [127:0] acc_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [64:0]  rem_q;
  logic [31:0]  mul_a, mul_b;
  logic [64:0]  div_trial;
  logic         div_ge;
  logic [48:0]  sq_r2, sq_t;
  logic         sq_ge;

  assign done_o = done_q;
  assign res_o  = acc_q;

  assign mul_a     = cnt_q[0] ? x_q[63:32] : x_q[31:0];
  assign mul_b     = cnt_q[1] ? y_q[63:32] : y_q[31:0];
  assign div_trial = {rem_q[63:0], x_q[63]};
  assign div_ge    = div_trial >= {1'b0, y_q};
  assign sq_r2     = {rem_q[46:0], x_q[87:86]};
  assign sq_t      = 49'({acc_q[43:0], 2'b01});
  assign sq_ge     = sq_r2 >= sq_t;

  always_comb begin
    case (op_q)
      MDU_MUL:  last = MUL_LAST;
      MDU_DIV:  last = DIV_LAST;
      default:  last = SQRT_LAST;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      cnt_q  <= 7'd0;
      op_q   <= MDU_MUL;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= 7'd0;
        pv_q   <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        pv_q  <= (op_q == MDU_MUL) && (cnt_q < MUL_LAST);
        if (cnt_q == last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      acc_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      case (op_q)
        MDU_MUL: begin
          if (cnt_q < MUL_LAST) begin
            pp_q <= mul_a * mul_b;
            sh_q <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
          end
          if (pv_q) begin
            acc_q <= acc_q + (128'(pp_q) << {sh_q, 5'b0});
          end
        end
        MDU_DIV: begin
          rem_q <= div_ge ? (div_trial - {1'b0, y_q}) : div_trial;
          x_q   <= {x_q[86:0], 1'b0};
          acc_q <= {acc_q[126:0], div_ge};
        end
        MDU_SQRT: begin
          rem_q <= 65'(sq_ge ? (sq_r2 - sq_t) : sq_r2);
          x_q   <= {x_q[85:0], 2'b00};
          acc_q <= {acc_q[126:0], sq_ge};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

endmodule

// ===== rtl/wpbl_back.sv =====
// Back end: sequencer that models motor power, scales it to the budget and solves each limit.
module wpbl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpbl_pkg::cfg_t     cfg_i,
  input  logic               q_valid_i,
  input  wpbl_pkg::item_t    q_item_i,
  output logic               q_pop_o,
  output logic               mdu_start_o,
  output wpbl_pkg::mdu_req_t mdu_req_o,
  input  logic               mdu_done_i,
  input  logic [127:0]       mdu_res_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wpbl_pkg::result_t  out_o
);
  import wpbl_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BUDGET = 3'd1;
  localparam logic [2:0] ST_POWER  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;
  localparam logic [2:0] ST_SOLVE  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  localparam logic [63:0] SAT_POS = 64'h0000_0000_7FFF_FFFF;

  logic [2:0]        state_q;
  logic [2:0]        step_q;
  logic [1:0]        k_q;
  logic              wait_q;
  item_t             item_q;
  logic signed [63:0] b_q;
  logic signed [63:0] pw_q [MOTORS];
  logic signed [63:0] p_q;
  logic [63:0]       m_q;
  logic [63:0]       total_q;
  logic              over_q;
  logic              sgn_q;
  logic signed [63:0] scaled_q;
  logic [63:0]       bmag_q;
  logic              bneg_q;
  logic [127:0]      bb_q;
  logic signed [63:0] c_q;
  logic [127:0]      fac_q;
  logic [127:0]      d_q;
  logic [63:0]       sq_q;
  fld_t [MOTORS-1:0] held_q;
  result_t           res_q;
  logic              out_valid_q;

  logic              use_mdu;
  logic signed [15:0] spd, cmd;
  logic [15:0]       sabs, cabs;
  logic signed [63:0] pw_cur;
  logic [63:0]       pwabs, babs, cabs64, numabs;
  logic signed [63:0] total;
  logic signed [63:0] p_fin, c_new, bsig, num, static_q24;
  logic [63:0]       res64;
  logic [13:0]       lim_mag;
  fld_t              lim;
  logic              last_motor;

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;
  assign mdu_start_o = use_mdu && !wait_q;

  assign spd        = 16'($signed(item_q.speed[k_q]));
  assign cmd        = 16'($signed(item_q.cmd[k_q]));
  assign sabs       = spd[15] ? 16'(-spd) : 16'(spd);
  assign cabs       = cmd[15] ? 16'(-cmd) : 16'(cmd);
  assign pw_cur     = pw_q[k_q];
  assign pwabs      = pw_cur[63] ? 64'(-pw_cur) : 64'(pw_cur);
  assign babs       = b_q[63] ? 64'(-b_q) : 64'(b_q);
  assign cabs64     = c_q[63] ? 64'(-c_q) : 64'(c_q);
  assign res64      = mdu_res_i[63:0];
  assign static_q24 = $signed(64'(cfg_i.static_pw) << 24);
  assign p_fin      = p_q + $signed(res64) + static_q24;
  assign c_new      = $signed(res64) + static_q24 - (scaled_q <<< 24);
  assign bsig       = bneg_q ? -$signed(bmag_q) : $signed(bmag_q);
  assign num        = (cmd > 16'sd0) ? ($signed(sq_q) - bsig) : (-bsig - $signed(sq_q));
  assign numabs     = num[63] ? 64'(-num) : 64'(num);
  assign lim_mag    = (res64 > 64'(cfg_i.clamp)) ? cfg_i.clamp : res64[13:0];
  assign lim        = num[63] ? -$signed({1'b0, lim_mag}) : $signed({1'b0, lim_mag});
  assign last_motor = (k_q == 2'(MOTORS - 1));

  always_comb begin
    total = '0;
    for (int i = 0; i < MOTORS; i++) begin
      if (!pw_q[i][63]) begin
        total = total + pw_q[i];
      end
    end
  end

  always_comb begin
    use_mdu        = 1'b0;
    mdu_req_o.op   = MDU_MUL;
    mdu_req_o.x    = '0;
    mdu_req_o.y    = '0;
    unique case (state_q)
      ST_BUDGET: begin
        use_mdu      = 1'b1;
        mdu_req_o.x  = 88'(64'(cfg_i.power_limit) * 64'(BUDGET_SCALE));
        mdu_req_o.y  = BUDGET_RECIP;
      end
      ST_POWER: begin
        use_mdu = 1'b1;
        case (step_q)
          3'd0: begin
            mdu_req_o.x = 88'(sabs);
            mdu_req_o.y = 64'(cabs);
          end
          3'd1: begin
            mdu_req_o.x = 88'(cfg_i.torque);
            mdu_req_o.y = m_q;
          end
          3'd2: begin
            mdu_req_o.x = 88'(sabs);
            mdu_req_o.y = 64'(sabs);
          end
          3'd3: begin
            mdu_req_o.x = 88'(cfg_i.speed_sq);
            mdu_req_o.y = m_q;
          end
          3'd4: begin
            mdu_req_o.x = 88'(cabs);
            mdu_req_o.y = 64'(cabs);
          end
          default: begin
            mdu_req_o.x = 88'(cfg_i.current_sq);
            mdu_req_o.y = m_q;
          end
        endcase
      end
      ST_SCALE: begin
        use_mdu = 1'b1;
        if (step_q == 3'd0) begin
          mdu_req_o.x = 88'(pwabs);
          mdu_req_o.y = babs;
        end else begin
          mdu_req_o.op = MDU_DIV;
          mdu_req_o.x  = 88'(m_q);
          mdu_req_o.y  = total_q;
        end
      end
      ST_SOLVE: begin
        use_mdu = (step_q != 3'd5);
        case (step_q)
          3'd0: begin
            mdu_req_o.x = 88'(cfg_i.torque);
            mdu_req_o.y = 64'(sabs);
          end
          3'd1: begin
            mdu_req_o.x = 88'(bmag_q);
            mdu_req_o.y = bmag_q;
          end
          3'd2: begin
            mdu_req_o.x = 88'(sabs);
            mdu_req_o.y = 64'(sabs);
          end
          3'd3: begin
            mdu_req_o.x = 88'(cfg_i.speed_sq);
            mdu_req_o.y = m_q;
          end
          3'd4: begin
            mdu_req_o.x = 88'({cfg_i.current_sq, 2'b00});
            mdu_req_o.y = cabs64;
          end
          3'd6: begin
            mdu_req_o.op = MDU_SQRT;
            mdu_req_o.x  = d_q[87:0];
          end
          3'd7: begin
            mdu_req_o.op = MDU_DIV;
            mdu_req_o.x  = 88'(numabs);
            mdu_req_o.y  = 64'({cfg_i.current_sq, 1'b0});
          end
          default: begin
            mdu_req_o.x = '0;
          end
        endcase
      end
      default: begin
        use_mdu = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 3'd0;
      k_q         <= 2'd0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (mdu_start_o) begin
        wait_q <= 1'b1;
      end else if (wait_q && mdu_done_i) begin
        wait_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            item_q  <= q_item_i;
            step_q  <= 3'd0;
            state_q <= ST_BUDGET;
          end
        end

        ST_BUDGET: begin
          if (wait_q && mdu_done_i) begin
            b_q     <= $signed(64'(mdu_res_i >> BUDGET_SHIFT))
                       - $signed(64'(pen_watts(item_q.pen)) << 16);
            k_q     <= 2'd0;
            step_q  <= 3'd0;
            state_q <= ST_POWER;
          end
        end

        ST_POWER: begin
          if (wait_q && mdu_done_i) begin
            step_q <= step_q + 3'd1;
            case (step_q)
              3'd0: begin
                m_q   <= res64;
                sgn_q <= spd[15] ^ cmd[15];
              end
              3'd1: p_q <= sgn_q ? -$signed(res64) : $signed(res64);
              3'd2: m_q <= res64;
              3'd3: p_q <= p_q + $signed(res64);
              3'd4: m_q <= res64;
              default: begin
                pw_q[k_q] <= p_fin >>> 24;
                step_q    <= 3'd0;
                if (last_motor) begin
                  state_q <= ST_DECIDE;
                end else begin
                  k_q <= k_q + 2'd1;
                end
              end
            endcase
          end
        end

        ST_DECIDE: begin
          k_q    <= 2'd0;
          step_q <= 3'd0;
          if (total > b_q) begin
            over_q  <= 1'b1;
            total_q <= 64'(total);
            state_q <= ST_SCALE;
          end else begin
            over_q  <= 1'b0;
            held_q  <= item_q.cmd;
            state_q <= ST_FINISH;
          end
        end

        ST_SCALE: begin
          if (wait_q && mdu_done_i) begin
            if (step_q == 3'd0) begin
              m_q   <= res64;
              sgn_q <= pw_cur[63] ^ b_q[63];
              if (total_q == 64'd0) begin
                scaled_q <= '0;
                if (cfg_i.current_sq == 24'd0) begin
                  held_q[k_q] <= '0;
                  if (last_motor) begin
                    state_q <= ST_FINISH;
                  end else begin
                    k_q <= k_q + 2'd1;
                  end
                end else begin
                  state_q <= ST_SOLVE;
                end
              end else begin
                step_q <= 3'd1;
              end
            end else begin
              step_q <= 3'd0;
              if (sgn_q && (res64 != 64'd0)) begin
                if (last_motor) begin
                  state_q <= ST_FINISH;
                end else begin
                  k_q <= k_q + 2'd1;
                end
              end else begin
                scaled_q <= $signed((res64 > SAT_POS) ? SAT_POS : res64);
                if (cfg_i.current_sq == 24'd0) begin
                  held_q[k_q] <= '0;
                  if (last_motor) begin
                    state_q <= ST_FINISH;
                  end else begin
                    k_q <= k_q + 2'd1;
                  end
                end else begin
                  state_q <= ST_SOLVE;
                end
              end
            end
          end
        end

        ST_SOLVE: begin
          if (step_q == 3'd5) begin
            if (c_q <= 64'sd0) begin
              d_q    <= bb_q + fac_q;
              step_q <= 3'd6;
            end else if (fac_q > bb_q) begin
              held_q[k_q] <= '0;
              step_q      <= 3'd0;
              if (last_motor) begin
                state_q <= ST_FINISH;
              end else begin
                k_q     <= k_q + 2'd1;
                state_q <= ST_SCALE;
              end
            end else begin
              d_q    <= bb_q - fac_q;
              step_q <= 3'd6;
            end
          end else if (wait_q && mdu_done_i) begin
            step_q <= step_q + 3'd1;
            case (step_q)
              3'd0: begin
                bmag_q <= res64;
                bneg_q <= spd[15];
              end
              3'd1: bb_q  <= mdu_res_i;
              3'd2: m_q   <= res64;
              3'd3: c_q   <= c_new;
              3'd4: fac_q <= mdu_res_i;
              3'd6: sq_q  <= res64;
              default: begin
                held_q[k_q] <= lim;
                step_q      <= 3'd0;
                if (last_motor) begin
                  state_q <= ST_FINISH;
                end else begin
                  k_q     <= k_q + 2'd1;
                  state_q <= ST_SCALE;
                end
              end
            endcase
          end
        end

        ST_FINISH: begin
          if (!out_valid_q) begin
            res_q.limit <= held_q;
            res_q.over  <= over_q;
            res_q.low   <= item_q.low;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/wheel_power_budget_limiter.sv =====
// Top level of the wheel power budget limiter: configuration registers, stream ports and wiring.
//
// One input transfer per control tick carries four wheel speeds, four current commands and the
// buffer energy; one output transfer returns four current limits with the over-budget and
// low-buffer flags. A front end takes the input and applies the low-buffer hysteresis, then
// queues the tick (two entries) for the solver, so input is taken while the solver works and
// while a result waits, as long as the queue has room. The solver runs every multiply, divide
// and square root through one shared arithmetic unit. Each tick needs the budget product and
// six products per motor; a tick over budget also needs the per-motor scale divide, square
// root and final divide. Configuration writes are always taken and must only be made while no
// tick is in flight.
module wheel_power_budget_limiter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // speed_lf, speed_rf, speed_lb, speed_rb, cmd_lf, cmd_rf, cmd_lb, cmd_rb, buffer_energy
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // limit_lf, limit_rf, limit_lb, limit_rb, over_budget, low_buffer
  output logic [63:0]  m_axis_tdata
);
  import wpbl_pkg::*;

  cfg_t              cfg_q;
  fld_t [MOTORS-1:0] speed, cmd;
  logic [BUF_W-1:0]  buffer_energy;
  logic              q_full, q_valid, q_push, q_pop;
  item_t             f_item, q_item;
  logic              mdu_start, mdu_done;
  mdu_req_t          mdu_req;
  logic [127:0]      mdu_res;
  result_t           res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      speed[i] = s_axis_tdata[FIELD_W*i +: FIELD_W];
      cmd[i]   = s_axis_tdata[FIELD_W*(MOTORS+i) +: FIELD_W];
    end
  end
  assign buffer_energy = s_axis_tdata[FIELD_W*2*MOTORS +: BUF_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_limit <= 9'd300;
      cfg_q.torque      <= 24'd2195590;
      cfg_q.current_sq  <= 24'd138540;
      cfg_q.speed_sq    <= 24'd214410;
      cfg_q.static_pw   <= 22'd229376;
      cfg_q.enter_low   <= 9'd10;
      cfg_q.exit_low    <= 9'd55;
      cfg_q.clamp       <= 14'd13000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_POWER_LIMIT: cfg_q.power_limit <= cfg_data_i[8:0];
        REG_TORQUE:      cfg_q.torque      <= cfg_data_i;
        REG_CURRENT_SQ:  cfg_q.current_sq  <= cfg_data_i;
        REG_SPEED_SQ:    cfg_q.speed_sq    <= cfg_data_i;
        REG_STATIC:      cfg_q.static_pw   <= cfg_data_i[21:0];
        REG_ENTER_LOW:   cfg_q.enter_low   <= cfg_data_i[8:0];
        REG_EXIT_LOW:    cfg_q.exit_low    <= cfg_data_i[8:0];
        REG_CLAMP:       cfg_q.clamp       <= cfg_data_i[13:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  wpbl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .enter_low_i     (cfg_q.enter_low),
    .exit_low_i      (cfg_q.exit_low),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .speed_i         (speed),
    .cmd_i           (cmd),
    .buffer_energy_i (buffer_energy),
    .full_i          (q_full),
    .push_o          (q_push),
    .item_o          (f_item)
  );

  wpbl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  wpbl_mdu u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdu_start),
    .req_i   (mdu_req),
    .done_o  (mdu_done),
    .res_o   (mdu_res)
  );

  wpbl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .mdu_start_o (mdu_start),
    .mdu_req_o   (mdu_req),
    .mdu_done_i  (mdu_done),
    .mdu_res_i   (mdu_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < MOTORS; i++) begin
      m_axis_tdata[FIELD_W*i +: FIELD_W] = res.limit[i];
    end
    m_axis_tdata[FIELD_W*MOTORS]     = res.over;
    m_axis_tdata[FIELD_W*MOTORS + 1] = res.low;
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the wheel power budget limiter.
import wpbl_pkg::*;

class limit_scoreboard;
  logic [8:0]  power_limit = 9'd300;
  logic [23:0] torque = 24'd2195590;
  logic [23:0] current_sq = 24'd138540;
  logic [23:0] speed_sq = 24'd214410;
  logic [21:0] static_pw = 22'd229376;
  logic [8:0]  enter_low = 9'd10;
  logic [8:0]  exit_low = 9'd55;
  logic [13:0] clamp = 14'd13000;
  bit          low_flag = 1'b0;
  logic [14:0] held [MOTORS] = '{default: '0};
  logic [63:0] pending_limits [$];
  int          errors = 0;

  function void write_reg(logic [2:0] idx, logic [23:0] v);
    case (idx)
      REG_POWER_LIMIT: power_limit = v[8:0];
      REG_TORQUE:      torque = v;
      REG_CURRENT_SQ:  current_sq = v;
      REG_SPEED_SQ:    speed_sq = v;
      REG_STATIC:      static_pw = v[21:0];
      REG_ENTER_LOW:   enter_low = v[8:0];
      REG_EXIT_LOW:    exit_low = v[8:0];
      REG_CLAMP:       clamp = v[13:0];
      default: ;
    endcase
  endfunction

  function logic [14:0] solve_current(longint spd, longint cmd, longint scaled);
    logic signed [131:0] a, b, c, disc, num, x, root, cand, lim;
    if (current_sq == 0) return '0;
    a = longint'(current_sq);
    b = longint'(torque) * spd;
    c = longint'(speed_sq) * spd * spd + (longint'(static_pw) <<< 24) - (scaled <<< 24);
    disc = b * b - 4 * a * c;
    if (disc < 0) return '0;
    root = 0;
    for (int k = 43; k >= 0; k--) begin
      cand = root | (132'sd1 <<< k);
      if (cand * cand <= disc) root = cand;
    end
    num = (cmd > 0) ? (-b + root) : (-b - root);
    x = num / (2 * a);
    lim = longint'(clamp);
    if (x > lim) x = lim;
    if (x < -lim) x = -lim;
    return x[14:0];
  endfunction

  function void note_tick(logic [135:0] d);
    longint spd [MOTORS];
    longint cmd [MOTORS];
    longint pw [MOTORS];
    longint p40, budget, total, scaled;
    logic [8:0] energy;
    bit over;
    energy = d[128:120];
    budget = (longint'(power_limit) * 75 * 65536) / 85;
    total = 0;
    if (low_flag) begin
      budget -= longint'(25) * 65536;
      if (energy >= exit_low) low_flag = 1'b0;
    end else if (energy < enter_low) begin
      low_flag = 1'b1;
      budget -= longint'(35) * 65536;
    end
    for (int i = 0; i < MOTORS; i++) begin
      spd[i] = longint'($signed(d[i*15 +: 15]));
      cmd[i] = longint'($signed(d[60 + i*15 +: 15]));
      p40 = longint'(torque) * spd[i] * cmd[i] + longint'(speed_sq) * spd[i] * spd[i]
          + longint'(current_sq) * cmd[i] * cmd[i] + (longint'(static_pw) <<< 24);
      pw[i] = p40 >>> 24;
      if (pw[i] >= 0) total += pw[i];
    end
    over = total > budget;
    for (int i = 0; i < MOTORS; i++) begin
      if (!over) begin
        held[i] = cmd[i][14:0];
      end else begin
        scaled = (total == 0) ? 0 : (pw[i] * budget) / total;
        if (scaled > longint'(32'h7FFF_FFFF)) scaled = longint'(32'h7FFF_FFFF);
        if (scaled < -longint'(33'h8000_0000)) scaled = -longint'(33'h8000_0000);
        if (scaled >= 0) held[i] = solve_current(spd[i], cmd[i], scaled);
      end
    end
    pending_limits.push_back({2'b00, low_flag, over, held[3], held[2], held[1], held[0]});
  endfunction

  function void check_result(logic [63:0] got);
    logic [63:0] want;
    bit bad;
    if (pending_limits.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transfer %h", got);
      return;
    end
    want = pending_limits.pop_front();
    bad = 1'b0;
    for (int i = 0; i < MOTORS; i++) if (got[i*15 +: 15] !== want[i*15 +: 15]) bad = 1'b1;
    if (got[60] !== want[60] || got[61] !== want[61]) bad = 1'b1;
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected limits %0d %0d %0d %0d over %b low %b, got %0d %0d %0d %0d over %b low %b",
                 $signed(want[14:0]), $signed(want[29:15]), $signed(want[44:30]),
                 $signed(want[59:45]), want[60], want[61],
                 $signed(got[14:0]), $signed(got[29:15]), $signed(got[44:30]),
                 $signed(got[59:45]), got[60], got[61]);
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 5000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [23:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;

  limit_scoreboard sb = new();
  int  sent = 0;
  int  send_idle = 22;
  int  recv_idle = 84;
  int  cycles = 0;
  bit  hold_go = 1'b0;
  logic hold_off = 1'b0;

  wheel_power_budget_limiter dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (8000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(logic [135:0] d);
    if ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(d);
    sent++;
    if (sent == 250) begin
      send_idle = 84;
      recv_idle = 22;
    end else if (sent == 500) begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (sent == 520) hold_go = 1'b1;
  endtask

  task automatic drain;
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (sb.pending_limits.size() != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
  endtask

  function automatic logic [135:0] pack_tick(logic [14:0] s0, logic [14:0] s1, logic [14:0] s2,
                                             logic [14:0] s3, logic [14:0] c0, logic [14:0] c1,
                                             logic [14:0] c2, logic [14:0] c3, logic [8:0] e);
    return {7'd0, e, c3, c2, c1, c0, s3, s2, s1, s0};
  endfunction

  function automatic logic [14:0] rand_field(bit narrow);
    logic [14:0] v;
    v = 15'($urandom());
    if (narrow) v = 15'($signed(v[9:0]));
    return v;
  endfunction

  function automatic logic [135:0] rand_tick();
    logic [135:0] d;
    bit narrow;
    narrow = $urandom_range(0, 2) == 0;
    d = '0;
    for (int i = 0; i < 2 * MOTORS; i++) d[i*15 +: 15] = rand_field(narrow);
    d[128:120] = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 60)) :
                 9'($urandom_range(0, 300));
    return d;
  endfunction

  task automatic apply_setting(int k);
    logic [23:0] v [8];
    v = '{24'd300, 24'd2195590, 24'd138540, 24'd214410, 24'd229376, 24'd10, 24'd55, 24'd13000};
    case (k)
      1: v = '{24'd45, 24'd2195590, 24'd138540, 24'd214410, 24'd229376, 24'd300, 24'd0,
               24'd16383};
      2: v = '{24'd500, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h3FFFFF, 24'd0, 24'd300, 24'd0};
      3: v = '{24'd200, 24'd2195590, 24'd0, 24'd214410, 24'd229376, 24'd30, 24'd100, 24'd9000};
      4: v = '{24'd45, 24'd1000, 24'd1, 24'd5000, 24'h3FFFFF, 24'd0, 24'd300, 24'd16383};
      5: v = '{24'd120, 24'd0, 24'd5000, 24'd0, 24'd0, 24'd100, 24'd100, 24'd500};
      default: ;
    endcase
    for (int r = 0; r < 8; r++) write_reg(3'(r), v[r]);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apply_setting(0);
    send_tick(pack_tick(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 9'd300));
    send_tick(pack_tick(15'h4000, 15'h4000, 15'h4000, 15'h4000,
                        15'h3FFF, 15'h3FFF, 15'h3FFF, 15'h3FFF, 9'd300));
    send_tick(pack_tick(15'h3FFF, 15'h4000, 15'h3FFF, 15'h4000,
                        15'h3FFF, 15'h3FFF, 15'h4000, 15'h4000, 9'd9));
    send_tick(pack_tick(15'h3FFF, 15'h3FFF, 15'h3FFF, 15'h3FFF,
                        15'h4000, 15'h4000, 15'h4000, 15'h4000, 9'd54));
    send_tick(pack_tick(15'd8000, -15'sd8000, 15'd100, 15'd0,
                        15'd0, 15'd0, 15'd0, 15'd0, 9'd55));
    send_tick(pack_tick(15'd8000, -15'sd8000, 15'd3000, -15'sd3000,
                        15'd12000, -15'sd12000, -15'sd12000, 15'd12000, 9'd10));
    send_tick(pack_tick(15'h3FFF, 15'h4000, 15'd0, 15'd1,
                        15'h4000, 15'h3FFF, 15'd0, -15'sd1, 9'd0));
    send_tick(pack_tick(15'd500, 15'd500, 15'd500, 15'd500,
                        15'd9000, 15'd9000, -15'sd9000, -15'sd9000, 9'd255));
    send_tick(pack_tick(15'h2AAA, 15'h5555, 15'h2AAA, 15'h5555,
                        15'h5555, 15'h2AAA, 15'h5555, 15'h2AAA, 9'd256));
    send_tick(pack_tick(15'd1, -15'sd1, 15'd2, -15'sd2, 15'd1, 15'd1, -15'sd1, 15'd0, 9'd60));
    for (int k = 1; k <= 6; k++) begin
      drain();
      apply_setting(k % 6);
      if (k == 4) begin
        send_tick(pack_tick(15'h3FFF, 15'h4000, 15'd0, 15'd100,
                            15'h3FFF, 15'h3FFF, 15'd0, 15'd50, 9'd300));
      end else if (k == 5) begin
        send_tick(pack_tick(15'h3FFF, 15'h4000, 15'h3FFF, 15'h4000,
                            15'h3FFF, 15'h3FFF, 15'h4000, 15'h4000, 9'd300));
      end
      for (int n = 0; n < 123; n++) send_tick(rand_tick());
    end
    drain();
    if (sb.errors == 0 && sb.pending_limits.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== wheel_power_budget_limiter.f =====
rtl/wpbl_pkg.sv
rtl/wpbl_queue.sv
rtl/wpbl_front.sv
rtl/wpbl_mdu.sv
rtl/wpbl_back.sv
rtl/wheel_power_budget_limiter.sv
tb/tb.sv
